FILE: design/pvenc_pkg.sv
package pvenc_pkg;

    localparam int unsigned ValW  = 64;
    localparam int unsigned ByteW = 8;
    localparam int unsigned MaxBytes = 9;
    localparam int unsigned BufW  = MaxBytes * ByteW;
    localparam int unsigned CntW  = $clog2(MaxBytes + 1);

    localparam logic [ByteW-1:0] PfxTwo   = 8'h80;
    localparam logic [ByteW-1:0] PfxThree = 8'hC0;
    localparam logic [ByteW-1:0] PfxFour  = 8'hE0;
    localparam logic [ByteW-1:0] PfxWord  = 8'hF0;
    localparam logic [ByteW-1:0] PfxLong  = 8'hF4;
    localparam logic [ByteW-1:0] PfxNeg   = 8'hF8;
    localparam logic [ByteW-1:0] PfxTiny  = 8'hFC;

    typedef logic [CntW-1:0] t_cnt;
    typedef logic [BufW-1:0] t_buf;

endpackage

FILE: design/prefix_varint_encoder.sv
// An accepted beat is registered in the input register, then encoded into the output
// buffer once it is empty or its last byte leaves; its first byte is then on the master side.
// Throughput: one output beat per cycle while m_axis_tready is high; a value is 1 to 9
// bytes, and the next value is loaded as the last byte of the previous one leaves.
// Reset (i_rst_n low, synchronous) empties the input register and the output buffer.
module prefix_varint_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last_byte
);

    logic                   r_in_vld;
    logic [63:0]            r_in_val;
    pvenc_pkg::t_buf        r_sh;
    pvenc_pkg::t_cnt        r_cnt;

    logic                   w_load;
    logic                   w_neg;
    logic [63:0]            w_val;
    logic [31:0]            w_cmp;
    pvenc_pkg::t_buf        w_enc;
    pvenc_pkg::t_cnt        w_len;
    pvenc_pkg::t_buf        n_sh;
    pvenc_pkg::t_cnt        n_cnt;

    assign w_load = r_in_vld &&
                    ((r_cnt == '0) || ((r_cnt == pvenc_pkg::t_cnt'(1)) && m_axis_tready));
    assign s_axis_tready = !r_in_vld || w_load;

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_sh[pvenc_pkg::BufW-1 -: pvenc_pkg::ByteW];
    assign m_axis_tlast  = (r_cnt == pvenc_pkg::t_cnt'(1));

    assign w_cmp = ~r_in_val[31:0];
    assign w_neg = r_in_val[63] && (r_in_val[63:32] == 32'hFFFF_FFFF);
    assign w_val = w_neg ? {32'd0, w_cmp} : r_in_val;

    always_comb begin
        if (w_val[63:7] == '0) begin
            w_enc = {w_val[7:0], 64'd0};
            w_len = pvenc_pkg::t_cnt'(1);
        end else if (w_val[63:14] == '0) begin
            w_enc = {pvenc_pkg::PfxTwo | w_val[15:8], w_val[7:0], 56'd0};
            w_len = pvenc_pkg::t_cnt'(2);
        end else if (w_val[63:21] == '0) begin
            w_enc = {pvenc_pkg::PfxThree | w_val[23:16], w_val[15:0], 48'd0};
            w_len = pvenc_pkg::t_cnt'(3);
        end else if (w_val[63:28] == '0) begin
            w_enc = {pvenc_pkg::PfxFour | w_val[31:24], w_val[23:0], 40'd0};
            w_len = pvenc_pkg::t_cnt'(4);
        end else if (w_val[63:32] == '0) begin
            w_enc = {pvenc_pkg::PfxWord, w_val[31:0], 32'd0};
            w_len = pvenc_pkg::t_cnt'(5);
        end else begin
            w_enc = {pvenc_pkg::PfxLong, w_val};
            w_len = pvenc_pkg::t_cnt'(9);
        end
    end

    always_comb begin
        n_sh  = r_sh;
        n_cnt = r_cnt;
        if (w_load) begin
            if (w_neg && (w_cmp[31:2] == '0)) begin
                n_sh  = {pvenc_pkg::PfxTiny | {6'd0, w_cmp[1:0]}, 64'd0};
                n_cnt = pvenc_pkg::t_cnt'(1);
            end else if (w_neg) begin
                n_sh  = {pvenc_pkg::PfxNeg, w_enc[pvenc_pkg::BufW-1:pvenc_pkg::ByteW]};
                n_cnt = w_len + pvenc_pkg::t_cnt'(1);
            end else begin
                n_sh  = w_enc;
                n_cnt = w_len;
            end
        end else if (m_axis_tvalid && m_axis_tready) begin
            n_sh  = {r_sh[pvenc_pkg::BufW-pvenc_pkg::ByteW-1:0], 8'd0};
            n_cnt = r_cnt - pvenc_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_val <= s_axis_tdata;
        end
        r_sh <= n_sh;
    end

endmodule

FILE: verif/prefix_varint_encoder_test.sv
module prefix_varint_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [pvenc_pkg::ByteW-1:0] code;
        logic                        last;
    } t_coded_byte;

    typedef enum int {
        KindShort,
        KindWide,
        KindNegSmall,
        KindNegWide,
        KindLargeNeg
    } t_value_kind;

    localparam int IdlePct = 22;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [pvenc_pkg::ValW-1:0]   s_axis_tdata = '0;   // [63:0] value
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [pvenc_pkg::ByteW-1:0]  m_axis_tdata;        // [7:0] out_byte
    logic                         m_axis_tlast;        // last_byte

    t_coded_byte pending_bytes[$];
    int          fail_count = 0;
    bit          src_gaps = 1'b1;
    bit          snk_stalls = 1'b1;

    prefix_varint_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_encoding(logic [pvenc_pkg::ValW-1:0] value);
        logic [pvenc_pkg::ValW-1:0]  mag;
        logic [pvenc_pkg::ByteW-1:0] codes[$];
        logic [pvenc_pkg::ByteW-1:0] head;
        int                          tail_len;
        mag = value;
        if (value[pvenc_pkg::ValW-1] && ((~value) < 64'h0000_0001_0000_0000)) begin
            mag = ~value;
            if (mag <= 64'd3) begin
                pending_bytes.push_back(t_coded_byte'{
                    code: pvenc_pkg::PfxTiny | mag[pvenc_pkg::ByteW-1:0],
                    last: 1'b1});
                return;
            end
            codes.push_back(pvenc_pkg::PfxNeg);
        end
        if (mag < 64'h80) begin
            head = mag[7:0];
            tail_len = 0;
        end else if (mag < 64'h4000) begin
            head = pvenc_pkg::PfxTwo | mag[15:8];
            tail_len = 1;
        end else if (mag < 64'h20_0000) begin
            head = pvenc_pkg::PfxThree | mag[23:16];
            tail_len = 2;
        end else if (mag < 64'h1000_0000) begin
            head = pvenc_pkg::PfxFour | mag[31:24];
            tail_len = 3;
        end else if (mag < 64'h0000_0001_0000_0000) begin
            head = pvenc_pkg::PfxWord;
            tail_len = 4;
        end else begin
            head = pvenc_pkg::PfxLong;
            tail_len = 8;
        end
        codes.push_back(head);
        for (int k = tail_len - 1; k >= 0; k--) begin
            codes.push_back(mag[8*k +: 8]);
        end
        foreach (codes[i]) begin
            pending_bytes.push_back(t_coded_byte'{code: codes[i],
                                                  last: (i == codes.size() - 1)});
        end
    endfunction

    function automatic logic [pvenc_pkg::ValW-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [pvenc_pkg::ValW-1:0] random_value(t_value_kind kind);
        logic [pvenc_pkg::ValW-1:0] v;
        case (kind)
            KindShort: begin
                v = random_word() >> $urandom_range(63, 32);
            end
            KindWide: begin
                v = random_word();
            end
            KindNegSmall: begin
                v = ~64'($urandom_range(3, 0));
            end
            KindNegWide: begin
                v = ~(64'($urandom) >> $urandom_range(31, 0));
            end
            default: begin
                v = random_word();
                v[63] = 1'b1;
                v[62] = 1'b0;
            end
        endcase
        return v;
    endfunction

    // enter and leave at a falling edge
    task automatic send_value(logic [pvenc_pkg::ValW-1:0] value);
        while (src_gaps && $urandom_range(99, 0) < IdlePct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_encoding(value);
        @(negedge i_clk);
    endtask

    task automatic run_boundary_values();
        logic [pvenc_pkg::ValW-1:0] values[$];
        values = '{64'h0, 64'h1, 64'h7F, 64'h80, 64'h3FFF, 64'h4000, 64'h1F_FFFF,
                   64'h20_0000, 64'hFFF_FFFF, 64'h1000_0000, 64'hFFFF_FFFF,
                   64'h1_0000_0000, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF};
        foreach (values[i]) send_value(values[i]);
    endtask

    task automatic run_negative_forms();
        logic [pvenc_pkg::ValW-1:0] comps[$];
        comps = '{64'h0, 64'h1, 64'h2, 64'h3, 64'h4, 64'h7F, 64'h80,
                  64'hFFFF_FFFF, 64'h1_0000_0000};
        foreach (comps[i]) send_value(~comps[i]);
    endtask

    task automatic run_random_values(int count);
        t_value_kind kind;
        for (int i = 0; i < count; i++) begin
            kind = t_value_kind'($urandom_range(int'(KindLargeNeg), int'(KindShort)));
            send_value(random_value(kind));
        end
    endtask

    task automatic run_burst_without_gaps(int count);
        src_gaps   = 1'b0;
        snk_stalls = 1'b0;
        run_random_values(count);
        src_gaps   = 1'b1;
        snk_stalls = 1'b1;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= !snk_stalls || ($urandom_range(99, 0) >= IdlePct);
    end

    always @(posedge i_clk) begin : check_beat
        t_coded_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (want.code !== m_axis_tdata || want.last !== m_axis_tlast) begin
                    $display("%0t: beat mismatch, expected %h last %b, actual %h last %b",
                             $time, want.code, want.last, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_boundary_values();
        run_negative_forms();
        run_random_values(50);
        run_burst_without_gaps(30);
        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("prefix_varint_encoder regression: pass");
        end else begin
            $display("prefix_varint_encoder regression: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("%0t: timeout", $time);
        $display("prefix_varint_encoder regression: fail");
        $finish;
    end

endmodule
